// ----- rtl/core/double_to_decimal_text_defines.svh -----
`ifndef DOUBLE_TO_DECIMAL_TEXT_DEFINES_SVH
`define DOUBLE_TO_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define DTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define DTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dtd_pkg.sv -----
`timescale 1ns / 1ps

package dtd_pkg;

    localparam int VALUE_W    = 64;
    localparam int FD_W       = 4;
    localparam int CHAR_W     = 8;
    localparam int INT_DIGITS = 20;
    localparam int CELL_IDX_W = 5;
    localparam int SCALE_W    = 34;
    localparam int MANT_W     = 53;
    localparam int EXP_W      = 11;
    localparam int PROD_W     = MANT_W + SCALE_W;
    localparam int ROUND_W    = PROD_W + 1;
    localparam int ROUND_POS  = PROD_W - MANT_W;
    localparam int SHIFT_W    = 7;
    localparam int CNT_W      = 7;

    localparam logic [EXP_W-1:0] EXP_ALL1 = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_INT  = 11'd1075;
    localparam logic [EXP_W-1:0] EXP_CLIP = 11'd1087;
    localparam logic [EXP_W-1:0] K_SUB    = 11'd1074;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic [FD_W-1:0]    frac_digits;
    } num_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              no_char;
        logic              int_clipped;
    } txt_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic               start;
        logic [MANT_W-1:0]  f;
        logic [EXP_W-1:0]   k;
        logic [SCALE_W-1:0] scale;
    } frac_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] fpart;
    } frac_rsp_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL,
        FR_NORM,
        FR_ROUND,
        FR_SHIFT
    } frac_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRAC,
        ST_FCONV,
        ST_ROUND,
        ST_ICONV,
        ST_SCAN,
        ST_TEXT,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FDIG
    } state_t;

    // 10^(d+1): scale of the truncated fraction product
    function automatic logic [SCALE_W-1:0] scale_of(input logic [FD_W-1:0] d);
        logic [SCALE_W-1:0] s;
        unique case (d)
            4'd0:    s = 34'd10;
            4'd1:    s = 34'd100;
            4'd2:    s = 34'd1000;
            4'd3:    s = 34'd10000;
            4'd4:    s = 34'd100000;
            4'd5:    s = 34'd1000000;
            4'd6:    s = 34'd10000000;
            4'd7:    s = 34'd100000000;
            4'd8:    s = 34'd1000000000;
            4'd9:    s = 34'd10000000000;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/core/double_to_decimal_text.sv -----
// Formats one IEEE 754 double as decimal ASCII text, one character per
// output request.
// Input channel num (num_valid / num_stall / num): value_bits and the number
// of fraction digits. num_stall stays high while a number is in work, so one
// number is handled at a time.
// Output channel txt (txt_valid / txt_stall / txt): char_code, last on the
// final character, no_char on the single request of an invalid digit count,
// int_clipped on every character of a number clipped to 2^64-1.
// Sequence: nan, inf, zero and an invalid digit count go straight to the
// text state, which loads the output register. Other numbers first pass a
// bit-serial product, its normalizing and rounding, the fraction and then
// the integer part through the 20-digit shift and add-3 cell chain with a
// digit rounding between them, and a scan. Characters then leave one per
// cycle while the output is not stalled.
// The output register lets a new number be accepted while the final
// character still waits. A stalled output holds its request and the
// sequence simply pauses. Reset empties the output register and returns the
// block to idle.
`timescale 1ns / 1ps
`include "double_to_decimal_text_defines.svh"

module double_to_decimal_text #(
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          num_valid,
    output logic          num_stall,
    input  dtd_pkg::num_t num,
    output logic          txt_valid,
    input  logic          txt_stall,
    output dtd_pkg::txt_t txt
);
    import dtd_pkg::*;

    localparam int FIDX_W = $clog2(MAX_FRAC_DIGITS + 1);

    state_t               st_reg, st_next;
    logic                 neg_reg, neg_next;
    logic                 clip_reg, clip_next;
    logic [VALUE_W-1:0]   ipart_reg, ipart_next;
    logic [FIDX_W-1:0]    d_reg, d_next;
    logic [VALUE_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [3:0]           fd_reg [1:MAX_FRAC_DIGITS];
    logic [3:0]           fd_next [1:MAX_FRAC_DIGITS];
    logic                 has_frac_reg, has_frac_next;
    logic [FIDX_W-1:0]    lo_reg, lo_next;
    logic [CELL_IDX_W-1:0] ip_reg, ip_next;
    logic [FIDX_W-1:0]    jp_reg, jp_next;
    logic [3:0][CHAR_W-1:0] text_reg, text_next;
    logic [1:0]           tlast_reg, tlast_next;
    logic [1:0]           tp_reg, tp_next;
    logic                 nochar_reg, nochar_next;
    txt_t                 txt_reg, txt_next;
    logic                 txt_valid_reg, txt_valid_next;

    logic                 accept;
    logic                 can_load;
    logic                 emit_last;

    // decode of the incoming number
    logic                 neg_w, bad_w, nan_w, inf_w, zero_w, clip_w, int_w;
    logic [EXP_W-1:0]     expo_w, e_w, k_w;
    logic [MANT_W-2:0]    mant_w;
    logic [MANT_W-1:0]    m_w, f_w;
    logic [VALUE_W-1:0]   ipart_w;

    frac_req_t            frac_req;
    frac_rsp_t            frac_rsp;
    cell_ctl_t            cell_ctl;
    logic [3:0]           cell_digit [INT_DIGITS];
    logic [INT_DIGITS:0]  sh;

    assign num_stall = (st_reg != ST_IDLE);
    assign accept    = num_valid && !num_stall;
    assign can_load  = !txt_valid_reg || !txt_stall;

    // split the double into integer part and leftover fraction bits
    always_comb
    begin
        neg_w  = num.value_bits[VALUE_W-1];
        expo_w = num.value_bits[VALUE_W-2 -: EXP_W];
        mant_w = num.value_bits[MANT_W-2:0];
        m_w    = {(expo_w != '0), mant_w};
        bad_w  = num.frac_digits > FD_W'(MAX_FRAC_DIGITS);
        nan_w  = (expo_w == EXP_ALL1) && (mant_w != '0);
        inf_w  = (expo_w == EXP_ALL1) && (mant_w == '0);
        zero_w = (expo_w == '0) && (mant_w == '0);
        clip_w = (expo_w >= EXP_CLIP);
        int_w  = (expo_w >= EXP_INT);
        e_w    = expo_w - EXP_INT;
        k_w    = (expo_w == '0) ? K_SUB : (EXP_INT - expo_w);
        if (clip_w)
        begin
            ipart_w = '1;
            f_w     = '0;
        end
        else if (int_w)
        begin
            ipart_w = {{(VALUE_W-MANT_W){1'b0}}, m_w} << e_w[3:0];
            f_w     = '0;
        end
        else
        begin
            ipart_w = (k_w >= EXP_W'(VALUE_W)) ? '0
                    : ({{(VALUE_W-MANT_W){1'b0}}, m_w} >> k_w[5:0]);
            f_w     = (k_w >= EXP_W'(MANT_W)) ? m_w
                    : (m_w & ~({MANT_W{1'b1}} << k_w[5:0]));
        end
    end

    assign frac_req.start = accept && !(bad_w || nan_w || inf_w || zero_w);
    assign frac_req.f     = f_w;
    assign frac_req.k     = k_w;
    assign frac_req.scale = scale_of(num.frac_digits);

    dtd_frac u_frac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (frac_req),
        .rsp   (frac_rsp)
    );

    // decimal digit chain, least significant cell takes the source MSB
    assign cell_ctl.clear = accept || (st_reg == ST_ROUND);
    assign cell_ctl.shift = (st_reg == ST_FCONV) || (st_reg == ST_ICONV);
    assign sh[0]          = src_reg[VALUE_W-1];

    for (genvar g = 0; g < INT_DIGITS; g++)
    begin : g_cell
        dtd_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .shift_in  (sh[g]),
            .shift_out (sh[g+1]),
            .digit     (cell_digit[g])
        );
    end

    // last flag of the character offered in this state
    always_comb
    begin
        unique case (st_reg)
            ST_TEXT: emit_last = (tp_reg == tlast_reg);
            ST_INT:  emit_last = (ip_reg == '0) && !has_frac_reg;
            ST_FDIG: emit_last = (jp_reg == lo_reg);
            default: emit_last = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = (bad_w || nan_w || inf_w || zero_w) ? ST_TEXT : ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (frac_rsp.done)
                begin
                    st_next = ST_FCONV;
                end
            end
            ST_FCONV:
            begin
                if (cnt_reg == CNT_W'(SCALE_W - 1))
                begin
                    st_next = ST_ROUND;
                end
            end
            ST_ROUND: st_next = ST_ICONV;
            ST_ICONV:
            begin
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    st_next = ST_SCAN;
                end
            end
            ST_SCAN: st_next = neg_reg ? ST_SIGN : ST_INT;
            ST_TEXT:
            begin
                if (can_load && emit_last)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (can_load)
                begin
                    st_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (can_load && (ip_reg == '0))
                begin
                    st_next = has_frac_reg ? ST_DOT : ST_IDLE;
                end
            end
            ST_DOT:
            begin
                if (can_load)
                begin
                    st_next = ST_FDIG;
                end
            end
            ST_FDIG:
            begin
                if (can_load && emit_last)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        logic                  c;
        logic [CELL_IDX_W-1:0] itop;
        logic [FIDX_W-1:0]     lo;
        logic                  any;
        neg_next      = neg_reg;
        clip_next     = clip_reg;
        ipart_next    = ipart_reg;
        d_next        = d_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;
        fd_next       = fd_reg;
        has_frac_next = has_frac_reg;
        lo_next       = lo_reg;
        ip_next       = ip_reg;
        jp_next       = jp_reg;
        text_next     = text_reg;
        tlast_next    = tlast_reg;
        tp_next       = tp_reg;
        nochar_next   = nochar_reg;
        txt_next      = txt_reg;
        c             = 1'b0;
        itop          = '0;
        lo            = '0;
        any           = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next    = neg_w;
                    clip_next   = clip_w;
                    ipart_next  = ipart_w;
                    d_next      = FIDX_W'(num.frac_digits);
                    tp_next     = '0;
                    nochar_next = 1'b0;
                    text_next   = {CH_NUL, CH_NUL, CH_NUL, CH_NUL};
                    tlast_next  = 2'd0;
                    if (bad_w)
                    begin
                        nochar_next = 1'b1;
                    end
                    else if (nan_w)
                    begin
                        text_next  = {CH_NUL, CH_N, CH_A, CH_N};
                        tlast_next = 2'd2;
                    end
                    else if (inf_w && neg_w)
                    begin
                        text_next  = {CH_F, CH_N, CH_I, CH_MINUS};
                        tlast_next = 2'd3;
                    end
                    else if (inf_w)
                    begin
                        text_next  = {CH_NUL, CH_F, CH_N, CH_I};
                        tlast_next = 2'd2;
                    end
                    else
                    begin
                        text_next = {CH_NUL, CH_NUL, CH_NUL, CH_ZERO};
                    end
                end
            end
            ST_FRAC:
            begin
                src_next = {frac_rsp.fpart, {(VALUE_W-SCALE_W){1'b0}}};
                cnt_next = '0;
            end
            ST_FCONV, ST_ICONV:
            begin
                src_next = src_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_ROUND:
            begin
                // round half up on the extra digit, carry through 9s
                c = (cell_digit[0] >= 4'd5);
                for (int j = 1; j <= MAX_FRAC_DIGITS; j++)
                begin
                    fd_next[j] = '0;
                    if (j <= int'(d_reg))
                    begin
                        if (c && (cell_digit[j] == 4'd9))
                        begin
                            fd_next[j] = '0;
                        end
                        else
                        begin
                            fd_next[j] = cell_digit[j] + {3'b0, c};
                            c = 1'b0;
                        end
                    end
                end
                if (c && (ipart_reg != '1))
                begin
                    ipart_next = ipart_reg + VALUE_W'(1);
                end
                src_next = (c && (ipart_reg != '1)) ? (ipart_reg + VALUE_W'(1)) : ipart_reg;
                cnt_next = '0;
            end
            ST_SCAN:
            begin
                // find the top integer digit and the last nonzero fraction digit
                for (int i = 0; i < INT_DIGITS; i++)
                begin
                    if (cell_digit[i] != 4'd0)
                    begin
                        itop = CELL_IDX_W'(i);
                    end
                end
                for (int j = MAX_FRAC_DIGITS; j >= 1; j--)
                begin
                    if (fd_reg[j] != 4'd0)
                    begin
                        lo  = FIDX_W'(j);
                        any = 1'b1;
                    end
                end
                ip_next       = itop;
                lo_next       = lo;
                has_frac_next = any;
                jp_next       = d_reg;
            end
            ST_TEXT:
            begin
                if (can_load)
                begin
                    txt_next.char_code   = text_reg[tp_reg];
                    txt_next.last        = emit_last;
                    txt_next.no_char     = nochar_reg;
                    txt_next.int_clipped = 1'b0;
                    tp_next              = tp_reg + 2'd1;
                end
            end
            ST_SIGN:
            begin
                if (can_load)
                begin
                    txt_next.char_code   = CH_MINUS;
                    txt_next.last        = 1'b0;
                    txt_next.no_char     = 1'b0;
                    txt_next.int_clipped = clip_reg;
                end
            end
            ST_INT:
            begin
                if (can_load)
                begin
                    txt_next.char_code   = CH_ZERO | {4'b0, cell_digit[ip_reg]};
                    txt_next.last        = emit_last;
                    txt_next.no_char     = 1'b0;
                    txt_next.int_clipped = clip_reg;
                    ip_next              = ip_reg - CELL_IDX_W'(1);
                end
            end
            ST_DOT:
            begin
                if (can_load)
                begin
                    txt_next.char_code   = CH_DOT;
                    txt_next.last        = 1'b0;
                    txt_next.no_char     = 1'b0;
                    txt_next.int_clipped = clip_reg;
                end
            end
            ST_FDIG:
            begin
                if (can_load)
                begin
                    txt_next.char_code   = CH_ZERO | {4'b0, fd_reg[jp_reg]};
                    txt_next.last        = emit_last;
                    txt_next.no_char     = 1'b0;
                    txt_next.int_clipped = clip_reg;
                    jp_next              = jp_reg - FIDX_W'(1);
                end
            end
            default:
            begin
                txt_next = txt_reg;
            end
        endcase
    end

    // output valid: load when a character is offered, drop when taken
    always_comb
    begin
        txt_valid_next = txt_valid_reg && txt_stall;
        if (can_load && ((st_reg == ST_TEXT) || (st_reg == ST_SIGN) || (st_reg == ST_INT)
                         || (st_reg == ST_DOT) || (st_reg == ST_FDIG)))
        begin
            txt_valid_next = 1'b1;
        end
    end

    assign txt_valid = txt_valid_reg;
    assign txt       = txt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            txt_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            txt_valid_reg <= txt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        clip_reg     <= clip_next;
        ipart_reg    <= ipart_next;
        d_reg        <= d_next;
        src_reg      <= src_next;
        cnt_reg      <= cnt_next;
        fd_reg       <= fd_next;
        has_frac_reg <= has_frac_next;
        lo_reg       <= lo_next;
        ip_reg       <= ip_next;
        jp_reg       <= jp_next;
        text_reg     <= text_next;
        tlast_reg    <= tlast_next;
        tp_reg       <= tp_next;
        nochar_reg   <= nochar_next;
        txt_reg      <= txt_next;
    end

    `DTD_ASSERT_IMPL(a_chain_no_overflow, (st_reg == ST_FCONV) || (st_reg == ST_ICONV), !sh[INT_DIGITS], "decimal cell chain overflowed")
    `DTD_ASSERT_IMPL(a_frac_done_waiting, frac_rsp.done, st_reg == ST_FRAC, "fraction unit finished while not awaited")
    `DTD_ASSERT_IMPL(a_nochar_is_last, txt_valid && txt.no_char, txt.last, "invalid digit count request not marked last")
    `DTD_ASSERT_NEXT(a_bad_digits_text, accept && bad_w, st_reg == ST_TEXT, "invalid digit count did not go to text output")

endmodule

// ----- rtl/core/dtd_cell.sv -----
`timescale 1ns / 1ps

module dtd_cell (
    input  logic              clk,
    input  dtd_pkg::cell_ctl_t ctl,
    input  logic              shift_in,
    output logic              shift_out,
    output logic [3:0]        digit
);
    import dtd_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 to digits of 5 and up, then shift one bit in from below
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.shift)
        begin
            digit_next = {adj[2:0], shift_in};
        end
    end

    assign shift_out = adj[3];
    assign digit     = digit_reg;

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ----- rtl/core/dtd_frac.sv -----
`timescale 1ns / 1ps

module dtd_frac (
    input  logic                clk,
    input  logic                rst_n,
    input  dtd_pkg::frac_req_t  req,
    output dtd_pkg::frac_rsp_t  rsp
);
    import dtd_pkg::*;

    frac_state_t        st_reg, st_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [SCALE_W-1:0] mul_reg, mul_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [MANT_W-1:0]  f_reg, f_next;
    logic [EXP_W-1:0]   k_reg, k_next;
    logic [5:0]         bit_reg, bit_next;
    logic [SHIFT_W-1:0] lz_reg, lz_next;
    logic [ROUND_W-1:0] r_reg, r_next;
    logic [SCALE_W-1:0] fpart_reg, fpart_next;
    logic               done_reg, done_next;

    logic               inc;
    logic [MANT_W:0]    r53;
    logic [ROUND_W-1:0] rn;
    logic [ROUND_W-1:0] q;

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            FR_IDLE:
            begin
                if (req.start)
                begin
                    st_next = FR_MUL;
                end
            end
            FR_MUL:
            begin
                if (bit_reg == 6'd0)
                begin
                    st_next = FR_NORM;
                end
            end
            FR_NORM:
            begin
                if ((acc_reg == '0) || acc_reg[PROD_W-1])
                begin
                    st_next = FR_ROUND;
                end
            end
            FR_ROUND: st_next = FR_SHIFT;
            FR_SHIFT: st_next = FR_IDLE;
            default:  st_next = FR_IDLE;
        endcase
    end

    // round the normalized product to 53 bits, nearest even
    always_comb
    begin
        inc = acc_reg[ROUND_POS-1] & ((|acc_reg[ROUND_POS-2:0]) | acc_reg[ROUND_POS]);
        r53 = {1'b0, acc_reg[PROD_W-1:ROUND_POS]} + (MANT_W+1)'(inc);
        rn  = (lz_reg <= SHIFT_W'(ROUND_POS - 1)) ? {r53, {ROUND_POS{1'b0}}}
                                                  : {1'b0, acc_reg};
        q   = (k_reg >= EXP_W'(ROUND_W)) ? '0 : (r_reg >> k_reg[SHIFT_W-1:0]);
    end

    // datapath
    always_comb
    begin
        acc_next   = acc_reg;
        mul_next   = mul_reg;
        scale_next = scale_reg;
        f_next     = f_reg;
        k_next     = k_reg;
        bit_next   = bit_reg;
        lz_next    = lz_reg;
        r_next     = r_reg;
        fpart_next = fpart_reg;
        done_next  = 1'b0;
        unique case (st_reg)
            FR_IDLE:
            begin
                if (req.start)
                begin
                    f_next     = req.f;
                    k_next     = req.k;
                    scale_next = req.scale;
                    mul_next   = req.scale;
                    acc_next   = '0;
                    bit_next   = 6'(SCALE_W - 1);
                    lz_next    = '0;
                end
            end
            FR_MUL:
            begin
                // one multiplier bit a cycle, most significant first
                acc_next = (acc_reg << 1)
                         + (mul_reg[SCALE_W-1] ? PROD_W'(f_reg) : '0);
                mul_next = mul_reg << 1;
                bit_next = bit_reg - 6'd1;
            end
            FR_NORM:
            begin
                if (!((acc_reg == '0) || acc_reg[PROD_W-1]))
                begin
                    if (acc_reg[PROD_W-1 -: 8] == 8'd0)
                    begin
                        acc_next = acc_reg << 8;
                        lz_next  = lz_reg + SHIFT_W'(8);
                    end
                    else
                    begin
                        acc_next = acc_reg << 1;
                        lz_next  = lz_reg + SHIFT_W'(1);
                    end
                end
            end
            FR_ROUND:
            begin
                r_next = rn >> lz_reg;
            end
            FR_SHIFT:
            begin
                fpart_next = (q < ROUND_W'(scale_reg)) ? q[SCALE_W-1:0] : '0;
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.fpart = fpart_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= FR_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mul_reg   <= mul_next;
        scale_reg <= scale_next;
        f_reg     <= f_next;
        k_reg     <= k_next;
        bit_reg   <= bit_next;
        lz_reg    <= lz_next;
        r_reg     <= r_next;
        fpart_reg <= fpart_next;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import dtd_pkg::*;

    localparam int MAX_FD       = 9;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic num_valid;
    logic num_stall;
    num_t num;
    logic txt_valid;
    logic txt_stall;
    txt_t txt;

    txt_t        char_q[$];
    int          err_cnt;
    int          cycle_cnt;
    int          num_cnt;
    int          char_cnt;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;

    double_to_decimal_text #(.MAX_FRAC_DIGITS(MAX_FD)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num       (num),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt       (txt)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Format one number into the characters the block should send
    function automatic void format_number(input num_t n);
        logic [7:0]  cq[$];
        logic        neg;
        logic [10:0] expo;
        logic [51:0] mant;
        logic [52:0] sig;
        logic [63:0] ipart;
        logic [63:0] mag_bits;
        logic        clip;
        real         mag;
        real         frac;
        real         scale;
        real         prod;
        longint      fpart;
        longint      unit;
        int          places;
        int          nd;
        logic [7:0]  dg[$];
        txt_t        t;
        if (n.frac_digits > MAX_FD)
        begin
            t.char_code   = CH_NUL;
            t.last        = 1'b1;
            t.no_char     = 1'b1;
            t.int_clipped = 1'b0;
            char_q.push_back(t);
            return;
        end
        neg  = n.value_bits[63];
        expo = n.value_bits[62:52];
        mant = n.value_bits[51:0];
        clip = 1'b0;
        if (expo == EXP_ALL1 && mant != 0)
        begin
            cq = '{CH_N, CH_A, CH_N};
        end
        else if (expo == EXP_ALL1)
        begin
            if (neg)
                cq.push_back(CH_MINUS);
            cq.push_back(CH_I);
            cq.push_back(CH_N);
            cq.push_back(CH_F);
        end
        else if (expo == 0 && mant == 0)
        begin
            cq.push_back(CH_ZERO);
        end
        else
        begin
            mag_bits = {1'b0, n.value_bits[62:0]};
            mag      = $bitstoreal(mag_bits);
            sig      = {(expo != 0), mant};
            // Split integer and fraction parts, saturating huge values
            if (expo >= EXP_CLIP)
            begin
                ipart = '1;
                clip  = 1'b1;
                frac  = 0.0;
            end
            else
            begin
                if (expo < 11'd1023)
                    ipart = 0;
                else if (expo >= EXP_INT)
                    ipart = 64'(sig) << (expo - EXP_INT);
                else
                    ipart = 64'(sig) >> (EXP_INT - expo);
                frac = mag - real'(ipart);
            end
            scale = 1.0;
            unit  = 1;
            for (int i = 0; i < n.frac_digits; i++)
                unit = unit * 10;
            for (int i = 0; i <= n.frac_digits; i++)
                scale = scale * 10.0;
            prod  = frac * scale;
            fpart = 0;
            if (prod > 0.0 && prod < scale)
            begin
                fpart = longint'(prod);
                if (real'(fpart) > prod)
                    fpart = fpart - 1;
            end
            places = n.frac_digits;
            // Round half up at the last place, carry into the integer part
            if (fpart > 0)
            begin
                if (fpart % 10 >= 5)
                    fpart = fpart + 5;
                fpart = fpart / 10;
                if (fpart >= unit)
                begin
                    fpart = 0;
                    if (ipart != '1)
                        ipart = ipart + 1;
                end
                while (fpart != 0 && fpart % 10 == 0)
                begin
                    fpart  = fpart / 10;
                    places = places - 1;
                end
            end
            if (neg)
                cq.push_back(CH_MINUS);
            do
            begin
                dg.push_front(CH_ZERO + 8'(ipart % 10));
                ipart = ipart / 10;
            end
            while (ipart > 0);
            cq = {cq, dg};
            if (fpart > 0)
            begin
                cq.push_back(CH_DOT);
                dg.delete();
                nd = 0;
                while (fpart > 0)
                begin
                    dg.push_front(CH_ZERO + 8'(fpart % 10));
                    fpart = fpart / 10;
                    nd++;
                end
                while (nd < places)
                begin
                    dg.push_front(CH_ZERO);
                    nd++;
                end
                cq = {cq, dg};
            end
        end
        foreach (cq[i])
        begin
            t.char_code   = cq[i];
            t.last        = (i == cq.size() - 1);
            t.no_char     = 1'b0;
            t.int_clipped = clip;
            char_q.push_back(t);
        end
    endfunction

    task automatic report_mismatch(input string what, input txt_t got, input txt_t want);
        $display("MISMATCH %s at cycle %0d: got %h/%b%b%b want %h/%b%b%b", what, cycle_cnt,
                 got.char_code, got.last, got.no_char, got.int_clipped,
                 want.char_code, want.last, want.no_char, want.int_clipped);
        err_cnt++;
    endtask

    // Check each accepted character against the oldest expected one
    always @(posedge clk)
    begin
        txt_t want;
        if (rst_n && txt_valid && !txt_stall)
        begin
            char_cnt++;
            if (char_q.size() == 0)
            begin
                report_mismatch("unexpected", txt, '0);
            end
            else
            begin
                want = char_q.pop_front();
                if (txt.char_code !== want.char_code)
                    report_mismatch("char_code", txt, want);
                else if (txt.last !== want.last)
                    report_mismatch("last", txt, want);
                else if (txt.no_char !== want.no_char)
                    report_mismatch("no_char", txt, want);
                else if (txt.int_clipped !== want.int_clipped)
                    report_mismatch("int_clipped", txt, want);
            end
        end
    end

    // Drive receiver stall: random, or a long counted hold
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            txt_stall   <= 1'b1;
        end
        else
        begin
            txt_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_num(input logic [63:0] bits, input logic [3:0] fd);
        num_t n;
        n.value_bits = bits;
        n.frac_digits = fd;
        num       <= n;
        num_valid <= 1'b1;
        do
            @(posedge clk);
        while (num_stall);
        format_number(n);
        num_cnt++;
        // Idle the sender after this request at random
        if ($urandom_range(99) < idle_pct)
        begin
            num_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        num_valid <= 1'b0;
        @(posedge clk);
        while (char_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_bits();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_shaped();
        real r;
        case ($urandom_range(5))
            0: return rand_bits();
            1: r = real'($urandom()) / 1000.0;
            2: r = real'($urandom_range(999)) + real'($urandom_range(99)) / 100.0 + 0.005;
            3: r = real'($urandom()) / real'($urandom_range(1, 100000));
            4: r = real'($urandom_range(9)) + 0.9999999999 - real'($urandom_range(9)) * 1.0e-11;
            default: r = real'($urandom()) * real'($urandom()) * 1.0e6;
        endcase
        return {1'($urandom_range(1)), 63'($realtobits(r))};
    endfunction

    function automatic logic [3:0] rand_digits();
        if ($urandom_range(9) == 0)
            return 4'($urandom_range(15, 10));
        return 4'($urandom_range(MAX_FD));
    endfunction

    task automatic test_special_values();
        idle_pct  = 0;
        stall_pct = 0;
        send_num(64'h7FF8_0000_0000_0000, 4'd3);
        send_num(64'hFFF0_0000_0000_0001, 4'd0);
        send_num(64'h7FF0_0000_0000_0000, 4'd2);
        send_num(64'hFFF0_0000_0000_0000, 4'd9);
        send_num(64'h0000_0000_0000_0000, 4'd5);
        send_num(64'h8000_0000_0000_0000, 4'd5);
        send_num($realtobits(1.5), 4'd10);
        send_num($realtobits(-2.25), 4'd15);
        drain();
    endtask

    task automatic test_number_edges();
        send_num(64'h0000_0000_0000_0001, 4'd9);
        send_num(64'h7FEF_FFFF_FFFF_FFFF, 4'd4);
        send_num($realtobits(-18446744073709551616.0), 4'd2);
        send_num($realtobits(18446744073709549568.0), 4'd1);
        send_num($realtobits(0.95), 4'd1);
        send_num($realtobits(-9.9999), 4'd2);
        send_num($realtobits(3.0001), 4'd2);
        send_num($realtobits(0.05), 4'd1);
        send_num($realtobits(0.1), 4'd9);
        send_num($realtobits(-123.456), 4'd0);
        send_num($realtobits(7.25), 4'd4);
        send_num($realtobits(0.0625), 4'd9);
        send_num($realtobits(-0.004), 4'd3);
        drain();
    endtask

    task automatic test_random_numbers();
        int phase_idle[4]  = '{0, 81, 0, 7};
        int phase_stall[4] = '{0, 0, 81, 7};
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int i = 0; i < 50; i++)
                send_num(rand_shaped(), rand_digits());
            // Pause the sender until every expected character is out
            drain();
        end
    endtask

    task automatic test_output_hold();
        idle_pct    = 0;
        stall_pct   = 20;
        hold_cycles = 600;
        for (int i = 0; i < 20; i++)
            send_num(rand_shaped(), rand_digits());
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        num_valid   = 1'b0;
        num         = '0;
        txt_stall   = 1'b0;
        err_cnt     = 0;
        cycle_cnt   = 0;
        num_cnt     = 0;
        char_cnt    = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_number_edges();
        test_random_numbers();
        test_output_hold();
        $display("formatted %0d numbers into %0d characters, including nan, inf, zero,",
                 num_cnt, char_cnt);
        $display("clipping, rounding carries, invalid digit counts and long output holds");
        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
